@@ src/fm_sine_operator_top_defines.svh @@
// ---------------------------------------------------------------------------
// fm_sine_operator_top_defines.svh
// Assertion macros used by the FM sine operator top module.
// ---------------------------------------------------------------------------
`ifndef FM_SINE_OPERATOR_TOP_DEFINES_SVH
`define FM_SINE_OPERATOR_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

`define FMSO_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define FMSO_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define FMSO_ASSERT_IMPLY(name, clk, rst_n, ante, cons)

`define FMSO_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

@@ src/fmso_pkg.sv @@
// ---------------------------------------------------------------------------
// fmso_pkg
// Types, constants and the CORDIC angle table of the FM sine operator.
// ---------------------------------------------------------------------------
package fmso_pkg;

	localparam int PHASE_FRAC_BITS_DEF = 24;
	localparam int CORDIC_STAGES_DEF   = 16;
	localparam int CORDIC_STAGES_MAX   = 24;

	// CORDIC datapath width (x, y, z)
	localparam int CW = 34;

	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	localparam logic [1:0] REG_PARTIAL_RATIO = 2'd0;
	localparam logic [1:0] REG_MOD_INDEX     = 2'd1;
	localparam logic [1:0] REG_FM_ENABLE     = 2'd2;

	localparam logic [15:0] PARTIAL_RATIO_RST = 16'd256;

	// 1/(2*pi) in units of 2^-32
	localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

	localparam logic signed [CW-1:0] CORDIC_START = 34'sd652032874;
	localparam logic signed [CW-1:0] QUARTER_TURN = 34'sd1073741824;
	localparam logic signed [CW-1:0] HALF_TURN    = 34'sd2147483648;

	typedef struct packed {
		logic [15:0]        partial_ratio;
		logic signed [15:0] mod_index;
		logic               fm_enable;
	} fmso_cfg_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} fmso_vec_t;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] r;
		case (i)
			0:  r = 32'h20000000;
			1:  r = 32'h12E4051E;
			2:  r = 32'h09FB385B;
			3:  r = 32'h051111D4;
			4:  r = 32'h028B0D43;
			5:  r = 32'h0145D7E1;
			6:  r = 32'h00A2F61E;
			7:  r = 32'h00517C55;
			8:  r = 32'h0028BE53;
			9:  r = 32'h00145F2F;
			10: r = 32'h000A2F98;
			11: r = 32'h000517CC;
			12: r = 32'h00028BE6;
			13: r = 32'h000145F3;
			14: r = 32'h0000A2FA;
			15: r = 32'h0000517D;
			16: r = 32'h000028BE;
			17: r = 32'h0000145F;
			18: r = 32'h00000A30;
			19: r = 32'h00000518;
			20: r = 32'h0000028C;
			21: r = 32'h00000146;
			22: r = 32'h000000A3;
			23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

endpackage

@@ src/fmso_if.sv @@
// ---------------------------------------------------------------------------
// fmso_if
// Request channels of the FM sine operator: sample in, sine out.
// ---------------------------------------------------------------------------
interface fmso_in_if;
	logic               valid;
	logic               ready;
	logic [31:0]        sample_time;
	logic [23:0]        freq_value;
	logic signed [15:0] modulator_sample;

	modport source (output valid, sample_time, freq_value, modulator_sample, input ready);
	modport sink (input valid, sample_time, freq_value, modulator_sample, output ready);
endinterface

interface fmso_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sine_out;

	modport source (output valid, sine_out, input ready);
	modport sink (input valid, sine_out, output ready);
endinterface

@@ src/fm_sine_operator_top.sv @@
// ---------------------------------------------------------------------------
// fm_sine_operator_top
// FM synthesis sine operator: phase pipeline, CORDIC cell chain, output stage.
// ---------------------------------------------------------------------------
// Takes one request per cycle unless the output stalls; returns one Q1.15 sine
// per request, in order. Five phase stages (two multiplies, phase sum, quadrant
// fold), one cell per CORDIC rotation, and the rounding and saturating output
// register. Each stage has its own valid bit and advances once the next frees up,
// so bubbles close under a stalled output. APB registers sit at byte addresses
// 0, 4 and 8; the user must write them only while no request is in flight
// (unchecked). No stored state but the registers; no startup pass after reset.
`include "fm_sine_operator_top_defines.svh"

module fm_sine_operator_top #(
	parameter int PHASE_FRAC_BITS = fmso_pkg::PHASE_FRAC_BITS_DEF,
	parameter int CORDIC_STAGES   = fmso_pkg::CORDIC_STAGES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	fmso_in_if.sink                     in_ch,
	fmso_out_if.source                  out_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fmso_pkg::APB_AW-1:0] paddr,
	input  logic [fmso_pkg::APB_DW-1:0] pwdata,
	output logic [fmso_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);
	import fmso_pkg::*;

	localparam int RW = CW - 15;

	fmso_cfg_t            cfg;
	fmso_vec_t            vec_c [CORDIC_STAGES+1];
	logic [CORDIC_STAGES:0] valid_c;
	logic [CORDIC_STAGES:0] ready_c;

	logic                 out_valid_q;
	logic signed [15:0]   sine_q;
	logic signed [CW-1:0] y_last;
	logic signed [CW-1:0] y_rnd;
	logic signed [RW-1:0] s_rnd;
	logic signed [15:0]   s_sat;
	logic signed [CW-1:0] z_first;

	fmso_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fmso_phase #(
		.PHASE_FRAC_BITS (PHASE_FRAC_BITS)
	) u_phase (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cfg       (cfg),
		.vec_valid (valid_c[0]),
		.vec_ready (ready_c[0]),
		.vec       (vec_c[0])
	);

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		fmso_cell #(
			.STAGE (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_c[i]),
			.in_ready  (ready_c[i]),
			.in_vec    (vec_c[i]),
			.out_valid (valid_c[i+1]),
			.out_ready (ready_c[i+1]),
			.out_vec   (vec_c[i+1])
		);
	end

	assign ready_c[CORDIC_STAGES] = !out_valid_q || out_ch.ready;

	assign y_last = vec_c[CORDIC_STAGES].y;
	assign y_rnd  = y_last + CW'(16384);
	assign s_rnd  = RW'(y_rnd >>> 15);

	always_comb begin
		if (s_rnd > RW'(32767)) begin
			s_sat = 16'sh7FFF;
		end else if (s_rnd < -RW'(32768)) begin
			s_sat = -16'sh8000;
		end else begin
			s_sat = s_rnd[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_c[CORDIC_STAGES]) begin
			out_valid_q <= valid_c[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (ready_c[CORDIC_STAGES]) begin
			sine_q <= s_sat;
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.sine_out = sine_q;

	assign z_first = vec_c[0].z;

	`FMSO_ASSERT_IMPLY(a_ready_when_out_empty, clk, arst_n, !out_valid_q, in_ch.ready)
	`FMSO_ASSERT_IMPLY(a_fold_in_range, clk, arst_n, valid_c[0],
		(z_first <= QUARTER_TURN) && (z_first >= -QUARTER_TURN))
	`FMSO_ASSERT_NEXT(a_partial_write, clk, arst_n,
		psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_PARTIAL_RATIO),
		cfg.partial_ratio == $past(pwdata[15:0]))

endmodule

@@ src/fmso_regs.sv @@
// ---------------------------------------------------------------------------
// fmso_regs
// APB configuration registers: partial ratio, modulation index, FM enable.
// ---------------------------------------------------------------------------
module fmso_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fmso_pkg::APB_AW-1:0] paddr,
	input  logic [fmso_pkg::APB_DW-1:0] pwdata,
	output logic [fmso_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	output fmso_pkg::fmso_cfg_t         cfg
);
	import fmso_pkg::*;

	logic [1:0] reg_idx;
	logic       wr_en;
	fmso_cfg_t  cfg_q;

	assign reg_idx = paddr[APB_AW-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.partial_ratio <= PARTIAL_RATIO_RST;
			cfg_q.mod_index     <= '0;
			cfg_q.fm_enable     <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_PARTIAL_RATIO: cfg_q.partial_ratio <= pwdata[15:0];
				REG_MOD_INDEX:     cfg_q.mod_index     <= $signed(pwdata[15:0]);
				REG_FM_ENABLE:     cfg_q.fm_enable     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PARTIAL_RATIO: prdata = APB_DW'(cfg_q.partial_ratio);
			REG_MOD_INDEX:     prdata = APB_DW'(cfg_q.mod_index);
			REG_FM_ENABLE:     prdata = APB_DW'(cfg_q.fm_enable);
			default:           prdata = '0;
		endcase
	end

endmodule

@@ src/fmso_phase.sv @@
// ---------------------------------------------------------------------------
// fmso_phase
// Five-stage phase pipeline: carrier phase product, FM term, quadrant fold.
// ---------------------------------------------------------------------------
module fmso_phase #(
	parameter int PHASE_FRAC_BITS = fmso_pkg::PHASE_FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	fmso_in_if.sink             in_ch,
	input  fmso_pkg::fmso_cfg_t cfg,
	output logic                vec_valid,
	input  logic                vec_ready,
	output fmso_pkg::fmso_vec_t vec
);
	import fmso_pkg::*;

	localparam int P  = PHASE_FRAC_BITS;
	localparam int SH = 55 - P;
	localparam logic signed [62:0] RND    = 63'sd1 <<< (SH - 1);
	localparam logic signed [62:0] INV_TP = 63'(INV_TWO_PI_Q32);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	logic [35:0]        pa_s1;
	logic [23:0]        f_s1;
	logic signed [31:0] rad_s1;
	logic [47:0]        lo_s2;
	logic [11:0]        hi_s2;
	logic signed [62:0] turns_s2;
	logic [35:0]        frac_s3;
	logic signed [62:0] tr_s3;
	logic [P-1:0]       phase_s4;
	fmso_vec_t          vec_s5;

	logic [47:0]        pa_full;
	logic signed [31:0] rad;
	logic [31:0]        turn32;
	logic signed [CW-1:0] a_ext;
	logic signed [CW-1:0] z_fold;

	assign rdy5 = !v_s5 || vec_ready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ch.ready = rdy1;

	assign pa_full = 48'(cfg.partial_ratio) * 48'(in_ch.sample_time);
	assign rad     = 32'(cfg.mod_index) * 32'(in_ch.modulator_sample);

	assign turn32 = 32'(phase_s4) << (32 - P);
	assign a_ext  = CW'($signed(turn32));

	always_comb begin
		if (a_ext > QUARTER_TURN) begin
			z_fold = HALF_TURN - a_ext;
		end else if (a_ext < -QUARTER_TURN) begin
			z_fold = -HALF_TURN - a_ext;
		end else begin
			z_fold = a_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_ch.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			pa_s1  <= pa_full[35:0];
			f_s1   <= in_ch.freq_value;
			rad_s1 <= cfg.fm_enable ? rad : '0;
		end
		if (rdy2) begin
			lo_s2    <= 48'(pa_s1[23:0]) * 48'(f_s1);
			hi_s2    <= 12'(pa_s1[35:24] * f_s1);
			turns_s2 <= 63'(rad_s1) * INV_TP;
		end
		if (rdy3) begin
			frac_s3 <= lo_s2[35:0] + {hi_s2, 24'd0};
			tr_s3   <= turns_s2 + RND;
		end
		if (rdy4) begin
			phase_s4 <= frac_s3[35 -: P] + tr_s3[SH +: P];
		end
		if (rdy5) begin
			vec_s5.x <= CORDIC_START;
			vec_s5.y <= '0;
			vec_s5.z <= z_fold;
		end
	end

	assign vec_valid = v_s5;
	assign vec       = vec_s5;

endmodule

@@ src/fmso_cell.sv @@
// ---------------------------------------------------------------------------
// fmso_cell
// One CORDIC rotation cell with its own stage register and handshake.
// ---------------------------------------------------------------------------
module fmso_cell #(
	parameter int STAGE = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  fmso_pkg::fmso_vec_t in_vec,
	output logic                out_valid,
	input  logic                out_ready,
	output fmso_pkg::fmso_vec_t out_vec
);
	import fmso_pkg::*;

	logic signed [CW-1:0] x, y, z, dx, dy, ang;
	logic                 valid_q;
	fmso_vec_t            vec_q;

	assign x   = in_vec.x;
	assign y   = in_vec.y;
	assign z   = in_vec.z;
	assign dx  = y >>> STAGE;
	assign dy  = x >>> STAGE;
	assign ang = $signed({2'b00, atan_turn(STAGE)});

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			if (!z[CW-1]) begin
				vec_q.x <= x - dx;
				vec_q.y <= y + dy;
				vec_q.z <= z - ang;
			end else begin
				vec_q.x <= x + dx;
				vec_q.y <= y - dy;
				vec_q.z <= z + ang;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_vec   = vec_q;

endmodule

@@ sim/fm_sine_operator_top_test.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// fm_sine_operator_top_test
// Drives sample requests and APB register writes into the FM sine operator,
// predicts each sine from its own fixed-point phase and CORDIC model, and checks
// the returned requests in order under random sender gaps and receiver stalls.
// ---------------------------------------------------------------------------

class sine_tracker;
	localparam int PHASE_BITS = fmso_pkg::PHASE_FRAC_BITS_DEF;
	localparam int ROTATIONS  = fmso_pkg::CORDIC_STAGES_DEF;
	localparam longint INV_TWO_PI = 64'sd683565276;
	localparam longint GAIN_START = 64'sd652032874;
	localparam longint QUARTER    = 64'sh4000_0000;
	localparam longint HALF       = 64'sh8000_0000;
	localparam longint FULL       = 64'sh1_0000_0000;

	logic [15:0]        partial_ratio;
	logic signed [15:0] mod_index;
	logic               fm_enable;
	logic signed [15:0] pending_sines[$];
	int                 failures;

	function new();
		partial_ratio = fmso_pkg::PARTIAL_RATIO_RST;
		mod_index     = '0;
		fm_enable     = 1'b0;
		failures      = 0;
	endfunction

	function void set_register(logic [1:0] idx, logic [31:0] value);
		case (idx)
			fmso_pkg::REG_PARTIAL_RATIO: partial_ratio = value[15:0];
			fmso_pkg::REG_MOD_INDEX:     mod_index = value[15:0];
			fmso_pkg::REG_FM_ENABLE:     fm_enable = value[0];
			default: ;
		endcase
	endfunction

	// atan(2^-i) in 2^-32 turn units
	function longint arc_turn(int i);
		longint r;
		case (i)
			0:  r = 64'h20000000;
			1:  r = 64'h12E4051E;
			2:  r = 64'h09FB385B;
			3:  r = 64'h051111D4;
			4:  r = 64'h028B0D43;
			5:  r = 64'h0145D7E1;
			6:  r = 64'h00A2F61E;
			7:  r = 64'h00517C55;
			8:  r = 64'h0028BE53;
			9:  r = 64'h00145F2F;
			10: r = 64'h000A2F98;
			11: r = 64'h000517CC;
			12: r = 64'h00028BE6;
			13: r = 64'h000145F3;
			14: r = 64'h0000A2FA;
			15: r = 64'h0000517D;
			16: r = 64'h000028BE;
			17: r = 64'h0000145F;
			18: r = 64'h00000A30;
			19: r = 64'h00000518;
			20: r = 64'h0000028C;
			21: r = 64'h00000146;
			22: r = 64'h000000A3;
			23: r = 64'h00000051;
			default: r = 0;
		endcase
		return r;
	endfunction

	function logic signed [15:0] predict_sine(logic [31:0] t, logic [23:0] f,
			logic signed [15:0] m);
		logic [71:0]           prod;
		logic [PHASE_BITS-1:0] phase;
		logic [31:0]           turn32;
		longint                rad, turns, q, a, x, y, z, dx, dy, r;
		prod  = 72'(partial_ratio) * 72'(t) * 72'(f);
		phase = prod[35 -: PHASE_BITS];
		if (fm_enable) begin
			rad   = longint'(mod_index) * longint'(m);
			turns = rad * INV_TWO_PI;
			q     = (turns + (64'sd1 <<< (54 - PHASE_BITS))) >>> (55 - PHASE_BITS);
			phase = phase + q[PHASE_BITS-1:0];
		end
		turn32 = 32'(phase) << (32 - PHASE_BITS);
		a = longint'(turn32);
		if (a >= HALF)
			a = a - FULL;
		if (a > QUARTER)
			z = HALF - a;
		else if (a < -QUARTER)
			z = -HALF - a;
		else
			z = a;
		x = GAIN_START;
		y = 0;
		for (int i = 0; i < ROTATIONS && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - arc_turn(i);
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + arc_turn(i);
			end
		end
		r = (y + 64'sd16384) >>> 15;
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return r[15:0];
	endfunction

	function void note_sample(logic [31:0] t, logic [23:0] f, logic signed [15:0] m);
		logic signed [15:0] want;
		want = predict_sine(t, f, m);
		pending_sines.insert(pending_sines.size(), want);
	endfunction

	function void check_sine(logic signed [15:0] actual);
		logic signed [15:0] want;
		if (pending_sines.size() == 0) begin
			$error("sine_out with no pending request: got %0d", actual);
			failures++;
		end else begin
			want = pending_sines.pop_front();
			if (actual !== want) begin
				$error("sine_out mismatch: expected %0d, got %0d", want, actual);
				failures++;
			end
		end
	endfunction
endclass

module fm_sine_operator_top_test;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef enum logic [1:0] {RX_OPEN, RX_BUSY, RX_SPARSE, RX_BURSTY} rx_mode_t;

	logic                              clk;
	logic                              arst_n;
	logic                              psel;
	logic                              penable;
	logic                              pwrite;
	logic [fmso_pkg::APB_AW-1:0]       paddr;
	logic [fmso_pkg::APB_DW-1:0]       pwdata;
	logic [fmso_pkg::APB_DW-1:0]       prdata;
	logic                              pready;

	fmso_in_if  in_ch();
	fmso_out_if out_ch();

	sine_tracker tracker;
	int          burst_left;
	rx_mode_t    rx_mode;
	int          rx_hold;
	int          rx_tick;

	fm_sine_operator_top #(
		.PHASE_FRAC_BITS(fmso_pkg::PHASE_FRAC_BITS_DEF),
		.CORDIC_STAGES(fmso_pkg::CORDIC_STAGES_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#5_000_000;
		$display("fm_sine_operator_top_test NOT OK");
		$finish;
	end

	// receiver stall pattern: a random mode, chosen anew whenever its hold count runs out
	always @(posedge clk) begin
		if (rx_hold == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_hold = $urandom_range(20, 300);
		end
		rx_hold--;
		rx_tick++;
		case (rx_mode)
			RX_OPEN:   out_ch.ready <= 1'b1;
			RX_BUSY:   out_ch.ready <= ($urandom_range(0, 3) != 0);
			RX_SPARSE: out_ch.ready <= ($urandom_range(0, 4) == 0);
			default:   out_ch.ready <= rx_tick[3];
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			tracker.check_sine(out_ch.sine_out);
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		tracker.set_register(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic read_reg(input logic [1:0] idx);
		logic [15:0] want;
		logic [15:0] got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		got = prdata[15:0];
		case (idx)
			fmso_pkg::REG_PARTIAL_RATIO: want = tracker.partial_ratio;
			fmso_pkg::REG_MOD_INDEX:     want = tracker.mod_index;
			default: begin
				want = {15'd0, tracker.fm_enable};
				got  = {15'd0, prdata[0]};
			end
		endcase
		if (got !== want) begin
			$error("prdata mismatch at register %0d: expected %0h, got %0h", idx, want, got);
			tracker.failures++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// upper bits carry junk, the block must ignore them
	task automatic apply_settings(input logic [15:0] ratio, input logic [15:0] index,
			input logic fm);
		logic [31:0] junk;
		junk = $urandom;
		write_reg(fmso_pkg::REG_PARTIAL_RATIO, {junk[31:16], ratio});
		write_reg(fmso_pkg::REG_MOD_INDEX, {junk[15:0], index});
		write_reg(fmso_pkg::REG_FM_ENABLE, {junk[31:1], fm});
		read_reg(fmso_pkg::REG_PARTIAL_RATIO);
		read_reg(fmso_pkg::REG_MOD_INDEX);
		read_reg(fmso_pkg::REG_FM_ENABLE);
	endtask

	task automatic drain_requests();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending_sines.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_sample(input logic [31:0] t, input logic [23:0] f,
			input logic [15:0] m);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_ch.valid            <= 1'b1;
		in_ch.sample_time      <= t;
		in_ch.freq_value       <= f;
		in_ch.modulator_sample <= m;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		tracker.note_sample(t, f, m);
	endtask

	task automatic send_random_sample();
		logic [31:0] t;
		logic [23:0] f;
		logic [15:0] m;
		t = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'h00FF_FFFF) : $urandom;
		f = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 16'hFFFF)) : 24'($urandom);
		case ($urandom_range(0, 9))
			0:       m = 16'h8000;
			1:       m = 16'h7FFF;
			default: m = 16'($urandom);
		endcase
		send_sample(t, f, m);
	endtask

	initial begin
		logic [15:0] ratio;
		logic [15:0] index;
		tracker    = new();
		burst_left = 0;
		rx_hold    = 0;
		rx_tick    = 0;
		rx_mode    = RX_OPEN;
		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		in_ch.valid            = 1'b0;
		in_ch.sample_time      = '0;
		in_ch.freq_value       = '0;
		in_ch.modulator_sample = '0;
		out_ch.ready           = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// oscillator at reset settings: zero, quarter, half, three quarter, eighth turn
		send_sample(32'd0, 24'd0, 16'd0);
		send_sample(32'h0010_0000, 24'h40, 16'h1234);
		send_sample(32'h0010_0000, 24'h80, 16'h7FFF);
		send_sample(32'h0010_0000, 24'hC0, 16'h8000);
		send_sample(32'h0010_0000, 24'h20, 16'hFFFF);
		send_sample(32'hFFFF_FFFF, 24'hFF_FFFF, 16'h7FFF);
		send_sample(32'hFFFF_FFFF, 24'd0, 16'h8000);
		send_sample(32'd0, 24'hFF_FFFF, 16'hFFFF);
		drain_requests();

		// index set but modulation off: modulator must be ignored
		apply_settings(16'd256, 16'd12345, 1'b0);
		send_sample(32'h0010_0000, 24'h40, 16'h7FFF);
		send_sample(32'h0010_0000, 24'h40, 16'h8000);
		drain_requests();

		// largest ratio, most negative index, FM on
		apply_settings(16'hFFFF, 16'h8000, 1'b1);
		send_sample(32'd0, 24'd0, 16'h8000);
		send_sample(32'd0, 24'd0, 16'h7FFF);
		send_sample(32'd0, 24'd0, 16'd0);
		send_sample(32'hFFFF_FFFF, 24'hFF_FFFF, 16'h8000);
		send_sample(32'hFFFF_FFFF, 24'hFF_FFFF, 16'hFFFF);
		drain_requests();

		// zero ratio: phase comes only from modulation; write to an unused address
		apply_settings(16'd0, 16'h7FFF, 1'b1);
		write_reg(REG_UNUSED, $urandom);
		send_sample(32'hFFFF_FFFF, 24'hFF_FFFF, 16'h7FFF);
		send_sample(32'h1234_5678, 24'hABCDEF, 16'h8000);
		send_sample(32'd1, 24'd1, 16'd1);
		send_sample(32'd0, 24'd0, 16'hFFFF);
		send_sample(32'd0, 24'd0, 16'd0);
		drain_requests();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: apply_settings(16'hFFFF, 16'h7FFF, 1'b1);
				1: apply_settings(16'd0, 16'h8000, 1'b1);
				2: apply_settings(16'd256, 16'($urandom), 1'b0);
				default: begin
					ratio = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 1024))
						: 16'($urandom);
					index = 16'($urandom);
					apply_settings(ratio, index, 1'($urandom));
				end
			endcase
			for (int n = 0; n < 175; n++) begin
				if (ph == 3 && n == 80)
					drain_requests();
				send_random_sample();
			end
			drain_requests();
		end

		in_ch.valid <= 1'b0;
		while (tracker.pending_sines.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (tracker.failures == 0)
			$display("fm_sine_operator_top_test OK");
		else
			$display("fm_sine_operator_top_test NOT OK");
		$finish;
	end
endmodule
